### rtl/rip_pkg.sv
// Shared types, constants and the character decoder of the radix integer parser.
package rip_pkg;

	localparam logic [7:0] CH_ZERO        = 8'h30;
	localparam logic [7:0] CH_NINE        = 8'h39;
	localparam logic [7:0] CH_UPPER_A     = 8'h41;
	localparam logic [7:0] CH_UPPER_Z     = 8'h5A;
	localparam logic [7:0] CH_LOWER_A     = 8'h61;
	localparam logic [7:0] CH_LOWER_Z     = 8'h7A;
	localparam logic [7:0] CH_MINUS       = 8'h2D;
	localparam logic [7:0] UPPER_BASE     = 8'd55;  // 'A' - 10
	localparam logic [7:0] LOWER_BASE     = 8'd87;  // 'a' - 10
	localparam logic [7:0] NOT_DIGIT      = 8'hFF;

	localparam logic [5:0] RADIX_MIN      = 6'd2;
	localparam logic [5:0] RADIX_MAX      = 6'd36;
	localparam logic [5:0] RADIX_RESET    = 6'd10;
	localparam logic [63:0] MAX_ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam int ADDR_W = 5;

	typedef enum logic [1:0] {
		REG_RADIX       = 2'd0,
		REG_MAX_VALUE   = 2'd1,
		REG_SIGNED_MODE = 2'd2,
		REG_NONE        = 2'd3
	} rip_reg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_NO_DIGIT = 2'd3
	} rip_status_t;

	typedef struct packed {
		logic [5:0]  radix;
		logic [63:0] max_value;
		logic        signed_mode;
	} rip_cfg_t;

	// Digit value of a character, or NOT_DIGIT when it is none.
	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		d = NOT_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d = c - UPPER_BASE;
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			d = c - LOWER_BASE;
		end
		return d;
	endfunction

endpackage

### rtl/rip_intf.sv
// Stream interfaces for the character items and the result items.
interface rip_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       char_present;
	logic       end_of_text;

	modport source(output valid, output char_code, output char_present,
		output end_of_text, input ready);
	modport sink(input valid, input char_code, input char_present,
		input end_of_text, output ready);
endinterface

interface rip_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);
endinterface

### rtl/rip_cfg.sv
// Configuration register bank with an APB-style write and read port.
module rip_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rip_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready,
	output rip_pkg::rip_cfg_t         cfg
);

	rip_pkg::rip_reg_t reg_sel;
	logic              wr_en;
	logic [5:0]        radix_q;
	logic [63:0]       max_value_q;
	logic              signed_mode_q;

	// Registers sit on 8-byte boundaries.
	assign reg_sel = rip_pkg::rip_reg_t'(paddr[4:3]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= rip_pkg::RADIX_RESET;
			max_value_q   <= rip_pkg::MAX_ALL_ONES;
			signed_mode_q <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				rip_pkg::REG_RADIX:       radix_q       <= pwdata[5:0];
				rip_pkg::REG_MAX_VALUE:   max_value_q   <= pwdata;
				rip_pkg::REG_SIGNED_MODE: signed_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			rip_pkg::REG_RADIX:       prdata = {58'd0, radix_q};
			rip_pkg::REG_MAX_VALUE:   prdata = max_value_q;
			rip_pkg::REG_SIGNED_MODE: prdata = {63'd0, signed_mode_q};
			default:                  prdata = 64'd0;
		endcase
	end

	assign cfg.radix       = radix_q;
	assign cfg.max_value   = max_value_q;
	assign cfg.signed_mode = signed_mode_q;

endmodule

### rtl/rip_core.sv
// Parser datapath: input register, digit accumulation and result register.
module rip_core (
	input  logic              clk,
	input  logic              arst_n,
	input  rip_pkg::rip_cfg_t cfg,
	rip_char_if.sink          chars,
	rip_result_if.source      result
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        present_s1;
	logic        eot_s1;

	logic [63:0] acc_q;
	logic        seen_q;
	logic        ovf_q;
	logic        bad_q;
	logic        prefix_q;
	logic        neg_q;

	logic        out_valid_q;
	logic [63:0] value_q;
	logic [1:0]  status_q;

	logic        advance;
	logic        take;
	logic        load_res;
	logic [5:0]  r_eff;
	logic [7:0]  digit;
	logic        is_minus;
	logic [69:0] sum;
	logic        too_big;

	logic [63:0] acc_n;
	logic        seen_n;
	logic        ovf_n;
	logic        bad_n;
	logic        prefix_n;
	logic        neg_n;
	rip_pkg::rip_status_t status_n;
	logic [63:0] value_n;

	// The input stage only holds back when an end-of-text item finds the
	// result register still occupied.
	assign advance     = !(valid_s1 && eot_s1 && out_valid_q && !result.ready);
	assign chars.ready = !valid_s1 || advance;
	assign take        = valid_s1 && advance;
	assign load_res    = take && eot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1    <= chars.char_code;
			present_s1 <= chars.char_present;
			eot_s1     <= chars.end_of_text;
		end
	end

	always_comb begin
		if (cfg.radix < rip_pkg::RADIX_MIN) begin
			r_eff = rip_pkg::RADIX_MIN;
		end else if (cfg.radix > rip_pkg::RADIX_MAX) begin
			r_eff = rip_pkg::RADIX_MAX;
		end else begin
			r_eff = cfg.radix;
		end
	end

	assign digit    = rip_pkg::digit_of(char_s1);
	assign is_minus = cfg.signed_mode && prefix_q && (char_s1 == rip_pkg::CH_MINUS);

	// The full product never wraps, so one compare against the limit
	// replaces the quotient and remainder test.
	assign sum     = ({6'd0, acc_q} * {64'd0, r_eff}) + {62'd0, digit};
	assign too_big = sum > {6'd0, cfg.max_value};

	always_comb begin
		acc_n    = acc_q;
		seen_n   = seen_q;
		ovf_n    = ovf_q;
		bad_n    = bad_q;
		prefix_n = prefix_q;
		neg_n    = neg_q;
		if (present_s1) begin
			if (is_minus) begin
				neg_n = 1'b1;
			end else begin
				prefix_n = 1'b0;
				if ({2'd0, r_eff} <= digit) begin
					bad_n = 1'b1;
				end else begin
					seen_n = 1'b1;
					if (ovf_q || too_big) begin
						ovf_n = 1'b1;
					end else begin
						acc_n = sum[63:0];
					end
				end
			end
		end

		value_n = 64'd0;
		if (bad_n) begin
			status_n = rip_pkg::ST_BAD_CHAR;
		end else if (ovf_n) begin
			status_n = rip_pkg::ST_OVERFLOW;
		end else if (!seen_n) begin
			status_n = rip_pkg::ST_NO_DIGIT;
		end else begin
			status_n = rip_pkg::ST_OK;
			value_n  = neg_n ? (64'd0 - acc_n) : acc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= 64'd0;
			seen_q   <= 1'b0;
			ovf_q    <= 1'b0;
			bad_q    <= 1'b0;
			prefix_q <= 1'b1;
			neg_q    <= 1'b0;
		end else if (take) begin
			if (eot_s1) begin
				acc_q    <= 64'd0;
				seen_q   <= 1'b0;
				ovf_q    <= 1'b0;
				bad_q    <= 1'b0;
				prefix_q <= 1'b1;
				neg_q    <= 1'b0;
			end else begin
				acc_q    <= acc_n;
				seen_q   <= seen_n;
				ovf_q    <= ovf_n;
				bad_q    <= bad_n;
				prefix_q <= prefix_n;
				neg_q    <= neg_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			value_q  <= value_n;
			status_q <= status_n;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.value  = value_q;
	assign result.status = status_q;

`ifndef SYNTH
	// A fresh result appears only after an end-of-text item has been processed.
	a_res_from_eot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && eot_s1))
		else $error("result raised without an end-of-text item");

	// A failed parse always reports a zero value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != rip_pkg::ST_OK) |-> (value_q == 64'd0))
		else $error("non-zero value with failing status");

	// The text state is back at its start values after each result.
	a_state_clear: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> (acc_q == 64'd0) && prefix_q && !seen_q && !ovf_q && !bad_q && !neg_q)
		else $error("text state not cleared after end of text");

	// The result register is never overwritten while still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !load_res)
		else $error("result overwritten before it was taken");
`endif

endmodule

### rtl/radix_integer_parser.sv
// An accepted end-of-text item passes the input register and then loads the result register.
// Throughput: one character item per cycle while no end-of-text item is held; the accumulator
// multiply-add and the limit compare are combinational around the accumulator register.
// An end-of-text item waits in the input register only while the previous result is untaken.
// Reset (arst_n low, asynchronous) empties both stages, clears the text state and
// restores radix 10, max_value all ones and signed_mode 0.
module radix_integer_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	rip_char_if.sink                   chars,
	rip_result_if.source               result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rip_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready
);

	rip_pkg::rip_cfg_t cfg;

	rip_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rip_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.chars  (chars),
		.result (result)
	);

endmodule
